### sv/adg_pkg.sv
// Shared types and constants of the adjacent duplicate line grouper.
package adg_pkg;

  // Default depth of the line buffer, in characters.
  localparam int unsigned LineDepthDef = 1024;

  // Field widths.
  localparam int unsigned KindW  = 2;
  localparam int unsigned ChW    = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned FieldW = 8;
  localparam int unsigned CharsW = 10;
  localparam int unsigned LineW  = 32;
  localparam int unsigned CountW = 16;

  // Configuration port.
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [AddrW-1:0] AddrMode       = AddrW'(0);
  localparam logic [AddrW-1:0] AddrSkipFields = AddrW'(4);
  localparam logic [AddrW-1:0] AddrSkipChars  = AddrW'(8);

  // Item kinds carried in tuser.
  localparam logic [KindW-1:0] KindChar = 2'd0;
  localparam logic [KindW-1:0] KindEol  = 2'd1;
  localparam logic [KindW-1:0] KindEoi  = 2'd2;

  // Report filter modes; the unused code behaves as ModeAll.
  localparam logic [ModeW-1:0] ModeAll    = 2'd0;
  localparam logic [ModeW-1:0] ModeUnique = 2'd1;
  localparam logic [ModeW-1:0] ModeRepeat = 2'd2;

  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChTab   = 8'h09;

  localparam logic [CountW-1:0] CountMax = '1;

  // Where the current character falls in the key extraction of its line.
  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_FIELD  = 5'b00010,
    PH_BLANKS = 5'b00100,
    PH_CHARS  = 5'b01000,
    PH_KEY    = 5'b10000
  } phase_e;

endpackage

### sv/adjacent_duplicate_line_grouper_unit.sv
// Top level of the adjacent duplicate line grouper: key extraction, compare and group report.
//
//   Channel   Direction  Payload                                   Handshake
//   s_*       in         tuser[1:0] kind, tdata[7:0] ch            tvalid/tready
//   m_*       out        tdata[31:0] first line, [47:32] count     tvalid/tready
//   APB       in/out     mode @0x0, skip_fields @0x4, skip_chars @0x8  psel/penable
//
// One item is taken in every cycle while the key stage is ready. At an item's
// transfer the key stage, which reads and writes the line buffer at the key index,
// loads the compare stage. The compare stage then checks the buffered byte of the
// previous line and, when it advances, loads any group report into the output
// register. A stall on the output holds the compare stage once the output register
// is full; the key stage still takes one more item meanwhile if the compare stage is empty.
// Reset clears all control state at once; the line buffer needs no clearing pass.
module adjacent_duplicate_line_grouper_unit
  import adg_pkg::*;
#(
  parameter int unsigned LineDepth = LineDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_tdata_i,   // [7:0] ch
  input  logic [1:0]        s_tuser_i,   // [1:0] kind
  // Result stream
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [47:0]       m_tdata_o,   // [31:0] group_first_line, [47:32] repeat_count
  // Configuration port
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [AddrW-1:0]  paddr_i,
  input  logic [DataW-1:0]  pwdata_i,
  output logic [DataW-1:0]  prdata_o,
  output logic              pready_o
);

  // LW counts characters of a line, IW indexes the key and can hold the depth itself.
  localparam int unsigned LW = $clog2(LineDepth);
  localparam int unsigned IW = LW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ModeW-1:0]  mode_q;
  logic [FieldW-1:0] skip_fields_q;
  logic [CharsW-1:0] skip_chars_q;
  logic              cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeAll;
      skip_fields_q <= '0;
      skip_chars_q  <= '0;
    end else if (cfg_wr) begin
      case (paddr_i)
        AddrMode:       mode_q        <= pwdata_i[ModeW-1:0];
        AddrSkipFields: skip_fields_q <= pwdata_i[FieldW-1:0];
        AddrSkipChars:  skip_chars_q  <= pwdata_i[CharsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i)
      AddrMode:       prdata_o = DataW'(mode_q);
      AddrSkipFields: prdata_o = DataW'(skip_fields_q);
      AddrSkipChars:  prdata_o = DataW'(skip_chars_q);
      default:        prdata_o = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: the compare stage advances whenever the output register is free
  // or is being emptied; the key stage takes an item when the compare stage is
  // empty or advancing.
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic p_valid_q;
  logic adv;
  logic s_xfer;

  assign adv        = !out_valid_q || m_tready_i;
  assign s_tready_o = !p_valid_q || adv;
  assign s_xfer     = s_tvalid_i && s_tready_o;

  // ---------------------------------------------------------------------------
  // Key stage: skip fields and characters, address the line buffer.
  // ---------------------------------------------------------------------------
  logic [LW-1:0]     lcc_q;          // characters seen in the current line
  logic [IW-1:0]     idx_q;          // key index in the current line
  logic [IW-1:0]     stored_len_q;   // key length of the previous line
  phase_e            ph_q;
  logic [FieldW-1:0] fl_q;
  logic [CharsW-1:0] cl_q;

  logic [KindW-1:0]  kind;
  logic [ChW-1:0]    ch;
  logic              is_char;
  logic              blank;
  phase_e            ph0;
  phase_e            ph_n;
  logic [FieldW-1:0] fl0;
  logic [FieldW-1:0] fl_n;
  logic [FieldW-1:0] fl_dec;
  logic [CharsW-1:0] cl0;
  logic [CharsW-1:0] cl_n;
  logic              to_chars;
  logic              to_key;
  logic              key_we;
  logic [LW-1:0]     lcc_inc;
  logic              split;
  logic              eol;
  logic              eoi;
  logic [IW-1:0]     idx_after;

  assign kind    = s_tuser_i;
  assign ch      = s_tdata_i;
  assign is_char = (kind == KindChar);
  assign blank   = (ch == ChSpace) || (ch == ChTab);

  always_comb begin
    ph0 = ph_q;
    fl0 = fl_q;
    cl0 = cl_q;
    // The skips are loaded at the first character of every line.
    if (lcc_q == '0) begin
      fl0 = skip_fields_q;
      cl0 = skip_chars_q;
      ph0 = (skip_fields_q != '0) ? PH_LEAD : PH_CHARS;
    end
    ph_n     = ph0;
    fl_n     = fl0;
    cl_n     = cl0;
    fl_dec   = fl0;
    to_chars = 1'b0;
    to_key   = 1'b0;
    case (ph0)
      PH_LEAD: begin
        if (!blank) ph_n = PH_FIELD;
      end
      PH_FIELD: begin
        if (blank) ph_n = PH_BLANKS;
      end
      PH_BLANKS: begin
        // The first non-blank after a field closes that field.
        if (!blank) begin
          fl_dec = (fl0 != '0) ? fl0 - 1'b1 : fl0;
          fl_n   = fl_dec;
          if (fl_dec != '0) begin
            ph_n = PH_FIELD;
          end else begin
            to_chars = 1'b1;
          end
        end
      end
      PH_CHARS: to_chars = 1'b1;
      PH_KEY:   to_key   = 1'b1;
      default: ;
    endcase
    // Character skipping; once it runs out, this same character opens the key.
    if (to_chars) begin
      if (cl0 != '0) begin
        cl_n = cl0 - 1'b1;
        ph_n = PH_CHARS;
      end else begin
        ph_n   = PH_KEY;
        to_key = 1'b1;
      end
    end
  end

  assign key_we    = s_xfer && is_char && to_key && (idx_q < IW'(LineDepth));
  assign lcc_inc   = lcc_q + 1'b1;
  assign split     = is_char && (lcc_inc == LW'(LineDepth - 1));
  assign eol       = (kind == KindEol) || split;
  assign eoi       = (kind == KindEoi);
  assign idx_after = key_we ? idx_q + 1'b1 : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcc_q        <= '0;
      idx_q        <= '0;
      stored_len_q <= '0;
      ph_q         <= PH_LEAD;
      fl_q         <= '0;
      cl_q         <= '0;
    end else if (s_xfer) begin
      if (is_char) begin
        lcc_q <= lcc_inc;
        ph_q  <= ph_n;
        fl_q  <= fl_n;
        cl_q  <= cl_n;
        idx_q <= idx_after;
      end
      if (eol) begin
        stored_len_q <= idx_after;
        idx_q        <= '0;
        lcc_q        <= '0;
        ph_q         <= PH_LEAD;
      end else if (eoi) begin
        stored_len_q <= '0;
        idx_q        <= '0;
        lcc_q        <= '0;
        ph_q         <= PH_LEAD;
        fl_q         <= '0;
        cl_q         <= '0;
      end
    end
  end

  // The buffer returns the previous line's byte at this index while the new
  // byte replaces it in the same cycle.
  logic [ChW-1:0] rdata;

  adg_ram #(
    .Width (ChW),
    .Depth (LineDepth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (idx_q[LW-1:0]),
    .wdata_i (ch),
    .re_i    (s_xfer),
    .raddr_i (idx_q[LW-1:0]),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------------
  // Compare stage registers
  // ---------------------------------------------------------------------------
  logic           p_key_q;     // a key byte was written and must be compared
  logic           p_oob_q;     // key index is past the previous line's key
  logic [ChW-1:0] p_ch_q;
  logic           p_eol_q;
  logic           p_eoi_q;
  logic           p_len_eq_q;  // key length equals the previous line's

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (s_xfer) begin
      p_valid_q <= 1'b1;
    end else if (adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      p_key_q    <= key_we;
      p_oob_q    <= (idx_q >= stored_len_q);
      p_ch_q     <= ch;
      p_eol_q    <= eol;
      p_eoi_q    <= eoi;
      p_len_eq_q <= (idx_after == stored_len_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Compare stage: mismatch tracking, grouping and reporting.
  // ---------------------------------------------------------------------------
  logic              mm_q;
  logic [CountW-1:0] run_q;
  logic [LineW-1:0]  gs_q;
  logic [LineW-1:0]  ln_q;
  logic              hg_q;

  logic              p_go;
  logic              mm_now;
  logic              same;
  logic              passes;
  logic              emit;

  assign p_go   = p_valid_q && adv;
  assign mm_now = mm_q || (p_key_q && (p_oob_q || (rdata != p_ch_q)));
  assign same   = hg_q && !mm_now && p_len_eq_q;

  always_comb begin
    case (mode_q)
      ModeUnique: passes = (run_q == CountW'(1));
      ModeRepeat: passes = (run_q > CountW'(1));
      default:    passes = 1'b1;
    endcase
  end

  // A group is reported when a line with another key closes it, or at end of input, if the mode filter passes it.
  assign emit = p_go && hg_q && passes && ((p_eol_q && !same) || p_eoi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q  <= 1'b0;
      run_q <= '0;
      gs_q  <= '0;
      ln_q  <= '0;
      hg_q  <= 1'b0;
    end else if (p_go) begin
      if (p_eol_q) begin
        if (same) begin
          if (run_q != CountMax) run_q <= run_q + 1'b1;
        end else begin
          gs_q  <= ln_q;
          run_q <= CountW'(1);
          hg_q  <= 1'b1;
        end
        ln_q <= ln_q + 1'b1;
        mm_q <= 1'b0;
      end else if (p_eoi_q) begin
        mm_q  <= 1'b0;
        run_q <= '0;
        gs_q  <= '0;
        ln_q  <= '0;
        hg_q  <= 1'b0;
      end else begin
        mm_q <= mm_now;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [LineW-1:0]  out_line_q;
  logic [CountW-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_line_q  <= gs_q;
      out_count_q <= run_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_count_q, out_line_q};

endmodule

### sv/adg_ram.sv
// Generic single-write, single-read RAM with a registered, read-first output.
module adg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
